>>> rtl/lkda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkda_pkg
// Shared types, register indexes and reset values of the ladder key
// debounce and auto-repeat unit.
// ----------------------------------------------------------------------------
package lkda_pkg;

  localparam int DEF_TIME_BITS   = 32;
  localparam int DEF_SAMPLE_BITS = 10;

  localparam int KEY_W      = 3;
  localparam int THRESH_W   = 11;
  localparam int DUR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_BACK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_DOWN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_UP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_SELECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_TOP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD          = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT        = 3'd7;

  // reset values
  localparam logic [THRESH_W-1:0] RST_THRESH_BACK   = 11'd740;
  localparam logic [THRESH_W-1:0] RST_THRESH_DOWN   = 11'd780;
  localparam logic [THRESH_W-1:0] RST_THRESH_UP     = 11'd850;
  localparam logic [THRESH_W-1:0] RST_THRESH_SELECT = 11'd950;
  localparam logic [THRESH_W-1:0] RST_THRESH_TOP    = 11'd1023;
  localparam logic [DUR_W-1:0]    RST_DEBOUNCE      = 16'd100;
  localparam logic [DUR_W-1:0]    RST_HOLD          = 16'd600;
  localparam logic [DUR_W-1:0]    RST_REPEAT        = 16'd120;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE   = 3'd0,
    KEY_BACK   = 3'd1,
    KEY_DOWN   = 3'd2,
    KEY_UP     = 3'd3,
    KEY_SELECT = 3'd4
  } lkda_key_t;

  typedef struct packed {
    logic [THRESH_W-1:0] thresh_back;
    logic [THRESH_W-1:0] thresh_down;
    logic [THRESH_W-1:0] thresh_up;
    logic [THRESH_W-1:0] thresh_select;
    logic [THRESH_W-1:0] thresh_top;
    logic [DUR_W-1:0]    debounce_ms;
    logic [DUR_W-1:0]    hold_ms;
    logic [DUR_W-1:0]    repeat_ms;
  } lkda_cfg_t;

  typedef struct packed {
    lkda_key_t key_event;
    lkda_key_t stable_key;
  } lkda_result_t;

endpackage
`default_nettype wire

>>> rtl/lkda_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkda_in_if / lkda_out_if
// Valid/ready channels for converter samples and key results.
// ----------------------------------------------------------------------------
interface lkda_in_if #(
  parameter int SAMPLE_BITS = 10,
  parameter int TIME_BITS   = 32
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;
  logic [TIME_BITS-1:0]   now_ms;

  modport source (output valid, output adc_sample, output now_ms, input ready);
  modport sink   (input valid, input adc_sample, input now_ms, output ready);
endinterface

interface lkda_out_if import lkda_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_event;
  logic [KEY_W-1:0] stable_key;

  modport source (output valid, output key_event, output stable_key, input ready);
  modport sink   (input valid, input key_event, input stable_key, output ready);
endinterface
`default_nettype wire

>>> rtl/lkda_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkda_cfg
// Configuration register file: thresholds and debounce/hold/repeat times.
// ----------------------------------------------------------------------------
module lkda_cfg import lkda_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output lkda_cfg_t                  cfg
);

  lkda_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh_back   <= RST_THRESH_BACK;
      cfg_r.thresh_down   <= RST_THRESH_DOWN;
      cfg_r.thresh_up     <= RST_THRESH_UP;
      cfg_r.thresh_select <= RST_THRESH_SELECT;
      cfg_r.thresh_top    <= RST_THRESH_TOP;
      cfg_r.debounce_ms   <= RST_DEBOUNCE;
      cfg_r.hold_ms       <= RST_HOLD;
      cfg_r.repeat_ms     <= RST_REPEAT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESH_BACK:   cfg_r.thresh_back   <= cfg_data[THRESH_W-1:0];
        REG_THRESH_DOWN:   cfg_r.thresh_down   <= cfg_data[THRESH_W-1:0];
        REG_THRESH_UP:     cfg_r.thresh_up     <= cfg_data[THRESH_W-1:0];
        REG_THRESH_SELECT: cfg_r.thresh_select <= cfg_data[THRESH_W-1:0];
        REG_THRESH_TOP:    cfg_r.thresh_top    <= cfg_data[THRESH_W-1:0];
        REG_DEBOUNCE:      cfg_r.debounce_ms   <= cfg_data[DUR_W-1:0];
        REG_HOLD:          cfg_r.hold_ms       <= cfg_data[DUR_W-1:0];
        REG_REPEAT:        cfg_r.repeat_ms     <= cfg_data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> rtl/lkda_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkda_classify
// Sorts one converter sample into a key by the threshold ladder.
// ----------------------------------------------------------------------------
module lkda_classify import lkda_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire lkda_cfg_t              cfg,
  output lkda_key_t                   reading
);

  localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

  logic [CMP_W-1:0] s_ext;

  assign s_ext = CMP_W'(sample);

  // first match wins, thresholds are not reordered
  always_comb begin
    priority if (s_ext < CMP_W'(cfg.thresh_back))   reading = KEY_NONE;
    else if     (s_ext < CMP_W'(cfg.thresh_down))   reading = KEY_BACK;
    else if     (s_ext < CMP_W'(cfg.thresh_up))     reading = KEY_DOWN;
    else if     (s_ext < CMP_W'(cfg.thresh_select)) reading = KEY_UP;
    else if     (s_ext < CMP_W'(cfg.thresh_top))    reading = KEY_SELECT;
    else                                            reading = KEY_NONE;
  end

endmodule
`default_nettype wire

>>> rtl/lkda_track.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkda_track
// Debounce and auto-repeat state; produces the event of one sample.
// ----------------------------------------------------------------------------
module lkda_track import lkda_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire lkda_key_t            reading,
  input  wire logic [TIME_BITS-1:0] now_ms,
  input  wire lkda_cfg_t            cfg,
  output lkda_result_t              result
);

  lkda_key_t            last_reading_r, last_reading_nxt;
  lkda_key_t            debounced_r, debounced_nxt;
  logic [TIME_BITS-1:0] change_time_r, change_time_nxt;
  logic [TIME_BITS-1:0] press_time_r, press_time_nxt;
  logic [TIME_BITS-1:0] repeat_time_r, repeat_time_nxt;

  logic changed, deb_over, hold_over, rep_over, settle, pressed, repeating;

  assign changed = (reading != last_reading_r);

  // wrapping differences, strict greater-than; a fresh change has zero elapsed
  assign deb_over  = !changed &&
                     ((now_ms - change_time_r) > TIME_BITS'(cfg.debounce_ms));
  assign hold_over = (now_ms - press_time_r)  > TIME_BITS'(cfg.hold_ms);
  assign rep_over  = (now_ms - repeat_time_r) > TIME_BITS'(cfg.repeat_ms);

  assign settle    = deb_over && (reading != debounced_r);
  assign pressed   = settle && (reading != KEY_NONE);
  assign repeating = !settle && (debounced_r != KEY_NONE) && hold_over && rep_over;

  always_comb begin
    last_reading_nxt = reading;
    debounced_nxt    = settle ? reading : debounced_r;
    change_time_nxt  = changed ? now_ms : change_time_r;
    press_time_nxt   = pressed ? now_ms : press_time_r;
    repeat_time_nxt  = (pressed || repeating) ? now_ms : repeat_time_r;
    result.stable_key = debounced_nxt;
    result.key_event  = (pressed || repeating) ? debounced_nxt : KEY_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_reading_r <= KEY_NONE;
      debounced_r    <= KEY_NONE;
      change_time_r  <= '0;
      press_time_r   <= '0;
      repeat_time_r  <= '0;
    end else if (fire) begin
      last_reading_r <= last_reading_nxt;
      debounced_r    <= debounced_nxt;
      change_time_r  <= change_time_nxt;
      press_time_r   <= press_time_nxt;
      repeat_time_r  <= repeat_time_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_event_is_stable: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (result.key_event != KEY_NONE) |-> result.key_event == result.stable_key)
    else $error("event key differs from debounced key");

  a_change_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && changed |=> change_time_r == $past(now_ms))
    else $error("reading change did not restart debounce window");

  a_change_no_settle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && changed |=> debounced_r == $past(debounced_r))
    else $error("debounced key moved on a changing reading");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(debounced_r) && $stable(repeat_time_r) && $stable(last_reading_r))
    else $error("key state moved without a sample");
`endif

endmodule
`default_nettype wire

>>> rtl/ladder_key_debounce_autorepeat_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ladder_key_debounce_autorepeat_unit
// Resistor-ladder keypad debouncer with hold-delay auto-repeat.
//
// in_if carries one converter sample and its millisecond timestamp per beat;
// out_if returns one beat per sample: the event key (0 when none) and the
// debounced key after that sample. cfg_we/cfg_index/cfg_data write the five
// thresholds and the debounce, hold and repeat times; write them only while
// no sample is in flight.
// A sample is held in an input register, then classified and checked against
// the debounce state combinationally, and the result lands in the output
// register, from which the result beat is offered. One sample per cycle is
// sustained while out_if.ready stays high; the state update is combinational,
// with three wrapping subtract-and-compare paths.
// Reset (synchronous, active low) restores the register reset values and
// clears the key state and both pipeline stages. When the receiver stalls,
// the output register holds its beat and the input register still takes one
// more sample before in_if.ready drops.
// ----------------------------------------------------------------------------
module ladder_key_debounce_autorepeat_unit import lkda_pkg::*; #(
  parameter int TIME_BITS   = DEF_TIME_BITS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  lkda_in_if.sink                    in_if,
  lkda_out_if.source                 out_if
);

  lkda_cfg_t            cfg;
  lkda_key_t            reading;
  lkda_result_t         result;

  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [TIME_BITS-1:0]   s1_now_r;
  logic                   out_valid_r;
  lkda_result_t           out_result_r;

  logic in_fire, advance;

  // input stage moves when the output register is free or being drained
  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_fire     = in_if.valid && in_if.ready;

  lkda_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lkda_classify #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_classify (
    .sample  (s1_sample_r),
    .cfg     (cfg),
    .reading (reading)
  );

  lkda_track #(
    .TIME_BITS (TIME_BITS)
  ) u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .reading (reading),
    .now_ms  (s1_now_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_if.adc_sample;
      s1_now_r    <= in_if.now_ms;
    end
    if (advance) begin
      out_result_r <= result;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.key_event  = out_result_r.key_event;
  assign out_if.stable_key = out_result_r.stable_key;

endmodule
`default_nettype wire

>>> tb/tb_ladder_key_debounce_autorepeat_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ladder_key_debounce_autorepeat_unit
// Self-checking bench for the ladder key debounce and auto-repeat unit.
// A queue-fed driver offers ladder samples with timestamps, a shadow keypad
// model predicts the event and debounced key of every sample, and a monitor
// checks each result beat in order. The run walks through several register
// settings (reset values, narrow windows, zero and maximum times, thresholds
// out of order) under free flow, sender gaps, receiver stalls, both at once
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_ladder_key_debounce_autorepeat_unit;
  import lkda_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [DEF_SAMPLE_BITS-1:0] sample;
    logic [DEF_TIME_BITS-1:0]   stamp;
  } key_sample_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lkda_in_if #(.SAMPLE_BITS(DEF_SAMPLE_BITS), .TIME_BITS(DEF_TIME_BITS)) in_ch ();
  lkda_out_if out_ch ();

  ladder_key_debounce_autorepeat_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // shadow of the block's registers and key state
  lkda_cfg_t          keypad_cfg;
  lkda_key_t          prev_reading;
  lkda_key_t          held_key;
  logic [31:0]        t_change;
  logic [31:0]        t_press;
  logic [31:0]        t_repeat;

  key_sample_t        sample_q[$];
  lkda_result_t       key_result_q[$];

  idle_mode_t         idle_mode;
  logic               hold_off_req;
  logic               hold_off_done;
  int                 stall_left;
  int                 quiet_cycles;
  int                 n_samples;
  int                 n_results;
  int                 n_events;
  int                 n_settings;
  int                 fail_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic lkda_key_t classify_level(input logic [DEF_SAMPLE_BITS-1:0] s);
    logic [THRESH_W-1:0] v;
    v = THRESH_W'(s);
    if (v < keypad_cfg.thresh_back) return KEY_NONE;
    if (v < keypad_cfg.thresh_down) return KEY_BACK;
    if (v < keypad_cfg.thresh_up) return KEY_DOWN;
    if (v < keypad_cfg.thresh_select) return KEY_UP;
    if (v < keypad_cfg.thresh_top) return KEY_SELECT;
    return KEY_NONE;
  endfunction

  function automatic logic past_limit(input logic [31:0] now, input logic [31:0] since,
                                      input logic [DUR_W-1:0] lim);
    logic [31:0] d;
    d = now - since;
    return d > 32'(lim);
  endfunction

  // advance the shadow keypad by one sample and queue the expected beat
  function automatic void step_keypad(input key_sample_t smp);
    lkda_key_t    rd;
    lkda_key_t    ev;
    logic         pressed;
    lkda_result_t r;
    rd      = classify_level(smp.sample);
    ev      = KEY_NONE;
    pressed = 1'b0;
    if (rd != prev_reading) begin
      t_change     = smp.stamp;
      prev_reading = rd;
    end
    if (past_limit(smp.stamp, t_change, keypad_cfg.debounce_ms) && rd != held_key) begin
      held_key = rd;
      if (held_key != KEY_NONE) begin
        t_press  = smp.stamp;
        t_repeat = smp.stamp;
        ev       = held_key;
        pressed  = 1'b1;
      end
    end
    if (!pressed && held_key != KEY_NONE &&
        past_limit(smp.stamp, t_press, keypad_cfg.hold_ms) &&
        past_limit(smp.stamp, t_repeat, keypad_cfg.repeat_ms)) begin
      t_repeat = smp.stamp;
      ev       = held_key;
    end
    r.key_event  = ev;
    r.stable_key = held_key;
    key_result_q.push_back(r);
  endfunction

  // a sample from the band of key k between its two thresholds, or any code if that band is empty
  function automatic logic [DEF_SAMPLE_BITS-1:0] level_for(input lkda_key_t k);
    int lo;
    int hi;
    case (k)
      KEY_BACK: begin
        lo = int'(keypad_cfg.thresh_back);
        hi = int'(keypad_cfg.thresh_down) - 1;
      end
      KEY_DOWN: begin
        lo = int'(keypad_cfg.thresh_down);
        hi = int'(keypad_cfg.thresh_up) - 1;
      end
      KEY_UP: begin
        lo = int'(keypad_cfg.thresh_up);
        hi = int'(keypad_cfg.thresh_select) - 1;
      end
      KEY_SELECT: begin
        lo = int'(keypad_cfg.thresh_select);
        hi = int'(keypad_cfg.thresh_top) - 1;
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          lo = 0;
          hi = int'(keypad_cfg.thresh_back) - 1;
        end else begin
          lo = int'(keypad_cfg.thresh_top);
          hi = 1023;
        end
      end
    endcase
    if (hi > 1023) hi = 1023;
    if (lo > hi) return DEF_SAMPLE_BITS'($urandom_range(0, 1023));
    return DEF_SAMPLE_BITS'($urandom_range(hi, lo));
  endfunction

  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 73;
      IDLE_BOTH: return $urandom_range(0, 99) < 24;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 73;
      IDLE_BOTH: return $urandom_range(0, 99) < 24;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic void push_sample(input int s, input logic [31:0] t);
    key_sample_t smp;
    smp.sample = DEF_SAMPLE_BITS'(s);
    smp.stamp  = t;
    sample_q.push_back(smp);
  endfunction

  // driver: the offered beat is always the head of sample_q
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        step_keypad(sample_q.pop_front());
        n_samples++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_q.size() != 0 && !sender_idles()) begin
          in_ch.valid      <= 1'b1;
          in_ch.adc_sample <= sample_q[0].sample;
          in_ch.now_ms     <= sample_q[0].stamp;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with the one long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (hold_off_req && !hold_off_done) begin
      out_ch.ready  <= 1'b0;
      stall_left    <= HOLD_OFF_CYCLES;
      hold_off_done <= 1'b1;
    end else begin
      out_ch.ready <= !receiver_stalls();
    end
  end

  // monitor
  always @(posedge clk) begin
    lkda_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (key_result_q.size() == 0) begin
        $error("result beat with nothing expected: key_event %0d stable_key %0d",
               out_ch.key_event, out_ch.stable_key);
        fail_cnt++;
      end else begin
        want = key_result_q.pop_front();
        n_results++;
        if (want.key_event != KEY_NONE) n_events++;
        if (out_ch.key_event !== want.key_event) begin
          $error("key_event mismatch: expected %0d, got %0d", want.key_event, out_ch.key_event);
          fail_cnt++;
        end
        if (out_ch.stable_key !== want.stable_key) begin
          $error("stable_key mismatch: expected %0d, got %0d", want.stable_key,
                 out_ch.stable_key);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_THRESH_BACK:   keypad_cfg.thresh_back   = data[THRESH_W-1:0];
      REG_THRESH_DOWN:   keypad_cfg.thresh_down   = data[THRESH_W-1:0];
      REG_THRESH_UP:     keypad_cfg.thresh_up     = data[THRESH_W-1:0];
      REG_THRESH_SELECT: keypad_cfg.thresh_select = data[THRESH_W-1:0];
      REG_THRESH_TOP:    keypad_cfg.thresh_top    = data[THRESH_W-1:0];
      REG_DEBOUNCE:      keypad_cfg.debounce_ms   = data;
      REG_HOLD:          keypad_cfg.hold_ms       = data;
      REG_REPEAT:        keypad_cfg.repeat_ms     = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(input logic [15:0] back, input logic [15:0] down,
                              input logic [15:0] up, input logic [15:0] sel,
                              input logic [15:0] top, input logic [15:0] deb,
                              input logic [15:0] hold, input logic [15:0] rep);
    write_reg(REG_THRESH_BACK, back);
    write_reg(REG_THRESH_DOWN, down);
    write_reg(REG_THRESH_UP, up);
    write_reg(REG_THRESH_SELECT, sel);
    write_reg(REG_THRESH_TOP, top);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_HOLD, hold);
    write_reg(REG_REPEAT, rep);
    n_settings++;
  endtask

  // key presses held for a while with bounces and time jumps mixed in
  task automatic queue_key_runs(input int count, input int span);
    logic [31:0] stamp;
    lkda_key_t   k;
    int          len;
    int          made;
    stamp = $urandom();
    made  = 0;
    while (made < count) begin
      k   = lkda_key_t'($urandom_range(0, 4));
      len = $urandom_range(2, 25);
      for (int i = 0; i < len && made < count; i++) begin
        if ($urandom_range(0, 99) < 3) stamp = $urandom();
        else stamp = stamp + $urandom_range(0, span);
        if ($urandom_range(0, 99) < 8) push_sample($urandom_range(0, 1023), stamp);
        else push_sample(int'(level_for(k)), stamp);
        made++;
      end
    end
  endtask

  task automatic run_phase(input idle_mode_t mode);
    @(posedge clk);
    idle_mode <= mode;
    while (sample_q.size() != 0 || key_result_q.size() != 0) @(posedge clk);
    // let the pipeline settle so stray beats show up before the next write
    repeat (8) @(posedge clk);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.adc_sample = '0;
    in_ch.now_ms     = '0;
    out_ch.ready     = 1'b0;
    idle_mode        = IDLE_NONE;
    hold_off_req     = 1'b0;
    hold_off_done    = 1'b0;
    quiet_cycles     = 0;
    n_samples        = 0;
    n_results        = 0;
    n_events         = 0;
    n_settings       = 1;
    fail_cnt         = 0;
    keypad_cfg = '{thresh_back: RST_THRESH_BACK, thresh_down: RST_THRESH_DOWN,
                   thresh_up: RST_THRESH_UP, thresh_select: RST_THRESH_SELECT,
                   thresh_top: RST_THRESH_TOP, debounce_ms: RST_DEBOUNCE,
                   hold_ms: RST_HOLD, repeat_ms: RST_REPEAT};
    prev_reading = KEY_NONE;
    held_key     = KEY_NONE;
    t_change     = '0;
    t_press      = '0;
    t_repeat     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk with the reset settings
    push_sample(0, 0);
    push_sample(1023, 10);              // top code reads as no key
    push_sample(745, 1000);
    push_sample(745, 1050);
    push_sample(745, 1101);             // back press
    push_sample(760, 1500);
    push_sample(779, 1702);             // first repeat after hold
    push_sample(740, 1800);
    push_sample(745, 1823);             // repeat interval passed
    push_sample(1000, 2000);            // select bounce, back still repeats
    push_sample(1022, 2101);            // select press
    push_sample(950, 2200);
    push_sample(780, 3000);
    push_sample(849, 3200);             // down press
    push_sample(850, 3300);
    push_sample(949, 3500);             // up press
    push_sample(739, 3600);
    push_sample(0, 3800);               // release, no event
    push_sample(760, 100);
    push_sample(760, 50);               // time went backwards: huge elapsed
    push_sample(1023, 32'hFFFF_FFF0);
    push_sample(1023, 32'hFFFF_FFFF);
    push_sample(1023, 32'h0000_0070);   // window across the wrap
    queue_key_runs(50, 80);
    run_phase(IDLE_NONE);

    load_setting(100, 300, 500, 700, 900, 20, 150, 30);
    queue_key_runs(80, 25);
    run_phase(IDLE_SEND);

    // zero times; upper data bits on a threshold are dropped
    load_setting(16'hF800 | 16'd740, 780, 850, 950, 1023, 0, 0, 0);
    queue_key_runs(80, 3);
    run_phase(IDLE_RECV);

    // thresholds in random order, maximum times
    load_setting(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                 16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                 16'($urandom_range(0, 1024)), 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_key_runs(70, 40000);
    run_phase(IDLE_BOTH);

    load_setting(740, 780, 850, 950, 1023, 5, 40, 10);
    @(posedge clk);
    hold_off_req <= 1'b1;
    queue_key_runs(70, 12);
    run_phase(IDLE_NONE);

    // every sample reads as select
    load_setting(0, 0, 0, 0, 1024, 1, 3, 1);
    queue_key_runs(60, 3);
    run_phase(IDLE_BOTH);

    // every sample reads as no key
    load_setting(1024, 1024, 1024, 1024, 1024, 2, 4, 2);
    queue_key_runs(30, 5);
    run_phase(IDLE_SEND);

    repeat (10) @(posedge clk);
    if (key_result_q.size() != 0) begin
      $error("%0d expected results never arrived", key_result_q.size());
      fail_cnt++;
    end
    $display("covered %0d samples over %0d register settings with gaps, stalls and a hold-off",
             n_samples, n_settings);
    $display("checked %0d result beats, %0d of them key events", n_results, n_events);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lkda_pkg.sv
rtl/lkda_if.sv
rtl/lkda_cfg.sv
rtl/lkda_classify.sv
rtl/lkda_track.sv
rtl/ladder_key_debounce_autorepeat_unit.sv
tb/tb_ladder_key_debounce_autorepeat_unit.sv
